[design/ack_retransmit_tracker_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the acknowledgement retransmit tracker
// Shared property templates used by the top level.
// ---------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_TRACKER_TOP_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ART_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define ART_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

[design/art_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker package
// Shared types and codes of the acknowledgement retransmit tracker.
// ---------------------------------------------------------------------------
package art_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_ACK  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    // Versions at or below this code are tracked.
    localparam logic [1:0] VER_LAST_TRACKED = 2'd1;

    localparam logic [1:0] KIND_TRACKED   = 2'd0;
    localparam logic [1:0] KIND_RESEND    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED   = 2'd2;
    localparam logic [1:0] KIND_UNTRACKED = 2'd3;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_SEND_UNT,
        OP_ACK,
        OP_TICK
    } art_op_t;

    typedef struct packed {
        art_op_t     op;
        logic [31:0] user;
        logic [31:0] session;
        logic [31:0] stamp;
        logic [3:0]  retries;
        logic [7:0]  timeout;
        logic [31:0] ip;
        logic [15:0] port;
    } art_cmd_t;

    typedef struct packed {
        logic [31:0] user;
        logic [31:0] session;
        logic [31:0] stamp;
        logic [3:0]  retries;
        logic [7:0]  countdown;
        logic [7:0]  reload;
        logic [31:0] ip;
        logic [15:0] port;
    } art_entry_t;

endpackage

[design/art_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker front end
// Accepts requests, classifies them and queues commands for the back end.
// ---------------------------------------------------------------------------
module art_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [31:0]      user_id,
    input  logic [31:0]      session_id,
    input  logic [31:0]      seq_number,
    input  logic [1:0]       proto_version,
    input  logic [3:0]       retry_count,
    input  logic [7:0]       timeout_ticks,
    input  logic [31:0]      dest_ip,
    input  logic [15:0]      dest_port,
    input  logic [31:0]      ack_tag,
    output art_pkg::art_cmd_t cmd,
    output logic             cmd_valid,
    input  logic             cmd_pop
);
    import art_pkg::*;

    art_cmd_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    art_cmd_t   new_cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        new_cmd.user    = user_id;
        new_cmd.session = session_id;
        new_cmd.retries = retry_count;
        new_cmd.timeout = timeout_ticks;
        new_cmd.ip      = dest_ip;
        new_cmd.port    = dest_port;
        new_cmd.stamp   = user_id + seq_number;
        case (mode)
            MODE_SEND:
            begin
                new_cmd.op = (proto_version <= VER_LAST_TRACKED) ? OP_SEND : OP_SEND_UNT;
            end
            MODE_ACK:
            begin
                new_cmd.op    = OP_ACK;
                new_cmd.stamp = ack_tag;
            end
            default:
            begin
                new_cmd.op = OP_TICK;
            end
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    // A no-operation request is taken and dropped here.
    assign push      = in_valid && !in_stall && (mode != MODE_NOP);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[design/art_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker back end
// Walks the entry table one slot at a time (an untracked send skips the walk) and produces results.
// ---------------------------------------------------------------------------
module art_back #(
    parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  art_pkg::art_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [3:0]        slot,
    output logic [31:0]       stamp,
    output logic [31:0]       owner_id,
    output logic [31:0]       resend_ip,
    output logic [15:0]       resend_port,
    output logic              last
);
    import art_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_SWR,
        S_FIN
    } state_t;

    state_t            state_reg;
    art_cmd_t          cur_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg [TABLE_DEPTH];
    art_entry_t        mem [TABLE_DEPTH];
    art_entry_t        rd_word_reg;

    logic              peer_found_reg;
    logic [7:0]        peer_reload_reg;
    logic [31:0]       peer_ip_reg;
    logic [15:0]       peer_port_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Held tick result; it goes out once the next one (or the end) is known.
    logic              pend_valid_reg;
    logic [1:0]        pend_kind_reg;
    logic [3:0]        pend_slot_reg;
    art_entry_t        pend_ent_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [3:0]        out_slot_reg;
    logic [31:0]       out_stamp_reg;
    logic [31:0]       out_owner_reg;
    logic [31:0]       out_ip_reg;
    logic [15:0]       out_port_reg;
    logic              out_last_reg;

    art_entry_t        ent;
    logic              vld;
    logic              umatch;
    logic              purge;
    logic              keep;
    logic              ev_resend;
    logic              ev_expire;
    logic              free_t;
    logic [3:0]        rt1;
    logic [7:0]        cd1;
    logic [7:0]        cd2;
    logic              out_free;
    logic              stall_ex;
    logic [IDX_W+3:0]  idx_ext;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    art_entry_t        mem_wdata;
    logic              send_ok;

    assign out_free = !out_valid_reg || !out_stall;
    assign cmd_pop  = (state_reg == S_IDLE);
    assign idx_ext  = {4'b0000, idx_reg};
    assign send_ok  = (cur_reg.op == OP_SEND) && free_found_reg;

    always_comb
    begin
        ent       = rd_word_reg;
        vld       = valid_reg[idx_reg];
        umatch    = (ent.user == cur_reg.user);
        purge     = vld && umatch && (ent.session != cur_reg.session);
        keep      = vld && !purge;
        ev_resend = vld && (ent.countdown == 8'd0) && (ent.retries != 4'd0);
        rt1       = ev_resend ? (ent.retries - 4'd1) : ent.retries;
        cd1       = ev_resend ? ent.reload : ent.countdown;
        free_t    = vld && (cd1 == 8'd0) && (rt1 == 4'd0);
        ev_expire = free_t && !ev_resend;
        cd2       = (cd1 != 8'd0) ? (cd1 - 8'd1) : cd1;
        stall_ex  = (cur_reg.op == OP_TICK) && (ev_resend || ev_expire)
                    && pend_valid_reg && !out_free;

        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = ent;
        if ((state_reg == S_EX) && (cur_reg.op == OP_TICK) && vld && !free_t && !stall_ex)
        begin
            mem_we              = 1'b1;
            mem_wdata.retries   = rt1;
            mem_wdata.countdown = cd2;
        end
        else if ((state_reg == S_SWR) && send_ok && out_free)
        begin
            mem_we              = 1'b1;
            mem_waddr           = free_idx_reg;
            mem_wdata.user      = cur_reg.user;
            mem_wdata.session   = cur_reg.session;
            mem_wdata.stamp     = cur_reg.stamp;
            mem_wdata.retries   = cur_reg.retries;
            mem_wdata.countdown = peer_found_reg ? peer_reload_reg : cur_reg.timeout;
            mem_wdata.reload    = peer_found_reg ? peer_reload_reg : cur_reg.timeout;
            mem_wdata.ip        = peer_found_reg ? peer_ip_reg : cur_reg.ip;
            mem_wdata.port      = peer_found_reg ? peer_port_reg : cur_reg.port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            peer_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg        <= cmd;
                        idx_reg        <= '0;
                        peer_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= (cmd.op == OP_SEND_UNT) ? S_SWR : S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EX;
                end
                S_EX:
                begin
                    if (!stall_ex)
                    begin
                        case (cur_reg.op)
                            OP_SEND:
                            begin
                                if (purge)
                                begin
                                    valid_reg[idx_reg] <= 1'b0;
                                end
                                if (keep && umatch && !peer_found_reg)
                                begin
                                    peer_found_reg  <= 1'b1;
                                    peer_reload_reg <= ent.reload;
                                    peer_ip_reg     <= ent.ip;
                                    peer_port_reg   <= ent.port;
                                end
                                if (!keep && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= idx_reg;
                                end
                            end
                            OP_ACK:
                            begin
                                if (vld && umatch && (ent.stamp == cur_reg.stamp))
                                begin
                                    valid_reg[idx_reg] <= 1'b0;
                                end
                            end
                            OP_TICK:
                            begin
                                if (free_t)
                                begin
                                    valid_reg[idx_reg] <= 1'b0;
                                end
                                if (ev_resend || ev_expire)
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        out_valid_reg <= 1'b1;
                                        out_kind_reg  <= pend_kind_reg;
                                        out_slot_reg  <= pend_slot_reg;
                                        out_stamp_reg <= pend_ent_reg.stamp;
                                        out_owner_reg <= pend_ent_reg.user;
                                        out_ip_reg    <= pend_ent_reg.ip;
                                        out_port_reg  <= pend_ent_reg.port;
                                        out_last_reg  <= 1'b0;
                                    end
                                    pend_valid_reg <= 1'b1;
                                    pend_kind_reg  <= ev_resend ? KIND_RESEND : KIND_EXPIRED;
                                    pend_slot_reg  <= idx_ext[3:0];
                                    pend_ent_reg   <= ent;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (idx_reg == IDX_LAST)
                        begin
                            case (cur_reg.op)
                                OP_SEND: state_reg <= S_SWR;
                                OP_TICK: state_reg <= S_FIN;
                                default: state_reg <= S_IDLE;
                            endcase
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SWR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_stamp_reg <= cur_reg.stamp;
                        out_owner_reg <= cur_reg.user;
                        out_last_reg  <= 1'b1;
                        if (send_ok)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            out_kind_reg <= KIND_TRACKED;
                            out_slot_reg <= 4'({4'b0000, free_idx_reg});
                            out_ip_reg   <= peer_found_reg ? peer_ip_reg : cur_reg.ip;
                            out_port_reg <= peer_found_reg ? peer_port_reg : cur_reg.port;
                        end
                        else
                        begin
                            out_kind_reg <= KIND_UNTRACKED;
                            out_slot_reg <= 4'd0;
                            out_ip_reg   <= 32'd0;
                            out_port_reg <= 16'd0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_FIN:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= pend_kind_reg;
                        out_slot_reg   <= pend_slot_reg;
                        out_stamp_reg  <= pend_ent_reg.stamp;
                        out_owner_reg  <= pend_ent_reg.user;
                        out_ip_reg     <= pend_ent_reg.ip;
                        out_port_reg   <= pend_ent_reg.port;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign slot        = out_slot_reg;
    assign stamp       = out_stamp_reg;
    assign owner_id    = out_owner_reg;
    assign resend_ip   = out_ip_reg;
    assign resend_port = out_port_reg;
    assign last        = out_last_reg;

endmodule

[design/ack_retransmit_tracker_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Acknowledgement retransmit tracker
// Table of sent packets awaiting acknowledgement, with resend timers.
// ---------------------------------------------------------------------------
// Flow: a request passes through the queue to the back end, which reads and
// then updates each slot in turn and registers each result on the output;
// an untracked send skips the table walk and goes straight to the output.
// The back end takes the next request only once it is back in idle; an output
// stall on a send or tick result can hold it back.
// Reset: asynchronous, clears all valid bits, the queue and the output stage.
module ack_retransmit_tracker_top #(
    parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] user_id,
    input  logic [31:0] session_id,
    input  logic [31:0] seq_number,
    input  logic [1:0]  proto_version,
    input  logic [3:0]  retry_count,
    input  logic [7:0]  timeout_ticks,
    input  logic [31:0] dest_ip,
    input  logic [15:0] dest_port,
    input  logic [31:0] ack_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [3:0]  slot,
    output logic [31:0] stamp,
    output logic [31:0] owner_id,
    output logic [31:0] resend_ip,
    output logic [15:0] resend_port,
    output logic        last
);
    import art_pkg::*;

    `include "ack_retransmit_tracker_top_assert.svh"

    // Commands pass from the classifier to the table sequencer through a
    // two-entry queue; the input stalls only when that queue is full.
    art_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_pop;

    // True when the result on the output belongs to a send request.
    logic     res_is_send;
    // True when the result carries no slot and no destination.
    logic     res_no_dest;

    art_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .user_id       (user_id),
        .session_id    (session_id),
        .seq_number    (seq_number),
        .proto_version (proto_version),
        .retry_count   (retry_count),
        .timeout_ticks (timeout_ticks),
        .dest_ip       (dest_ip),
        .dest_port     (dest_port),
        .ack_tag       (ack_tag),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    // The back end owns the table and the output register; tick results are
    // held one deep so the final one can be flagged as last.
    art_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .slot        (slot),
        .stamp       (stamp),
        .owner_id    (owner_id),
        .resend_ip   (resend_ip),
        .resend_port (resend_port),
        .last        (last)
    );

    assign res_is_send = (kind == KIND_TRACKED) || (kind == KIND_UNTRACKED);
    assign res_no_dest = (slot == 4'd0) && (resend_ip == 32'd0) && (resend_port == 16'd0);

    // A send always yields exactly one result, so it carries last.
    `ART_ASSERT_IMP(a_send_single, out_valid && res_is_send, last)
    // A rejected send reports no slot and no destination.
    `ART_ASSERT_IMP(a_untracked_zero, out_valid && kind == KIND_UNTRACKED, res_no_dest)
    // A result taken without last is followed by another tick result.
    `ART_ASSERT_NXT(a_more_follows, out_valid && !out_stall && !last, !(out_valid && res_is_send))

endmodule

[verif/ack_retransmit_tracker_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Retransmit tracker testbench
// Drives sends, acks, ticks and no-ops into the tracker through random
// request gaps and result stalls. A table model inside this bench predicts
// every result, and each result is checked field by field in order.
// ---------------------------------------------------------------------------
module ack_retransmit_tracker_top_tb;

    import art_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4 * DEPTH + 10;

    // One predicted result of the tracker.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] stamp;
        logic [31:0] owner;
        logic [31:0] ip;
        logic [15:0] port;
        logic        last;
    } tracker_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] user_id;
    logic [31:0] session_id;
    logic [31:0] seq_number;
    logic [1:0]  proto_version;
    logic [3:0]  retry_count;
    logic [7:0]  timeout_ticks;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [31:0] ack_tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] stamp;
    logic [31:0] owner_id;
    logic [31:0] resend_ip;
    logic [15:0] resend_port;
    logic        last;

    // The bench's own copy of the tracker table.
    logic        tbl_valid   [DEPTH];
    logic [31:0] tbl_user    [DEPTH];
    logic [31:0] tbl_session [DEPTH];
    logic [31:0] tbl_stamp   [DEPTH];
    logic [3:0]  tbl_retries [DEPTH];
    logic [7:0]  tbl_count   [DEPTH];
    logic [7:0]  tbl_reload  [DEPTH];
    logic [31:0] tbl_ip      [DEPTH];
    logic [15:0] tbl_port    [DEPTH];

    tracker_result_t pending_results[$];
    int errors;
    int cycles;
    int requests_sent;
    int results_seen;
    logic stall_random;

    // A small pool of users and sessions so that sends, acks and purges meet.
    logic [31:0] user_pool [4];
    logic [31:0] sess_pool [2];
    logic [31:0] recent_stamp [$];
    logic [31:0] recent_user  [$];

    ack_retransmit_tracker_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .user_id(user_id), .session_id(session_id),
        .seq_number(seq_number), .proto_version(proto_version),
        .retry_count(retry_count), .timeout_ticks(timeout_ticks),
        .dest_ip(dest_ip), .dest_port(dest_port), .ack_tag(ack_tag),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .slot(slot), .stamp(stamp), .owner_id(owner_id),
        .resend_ip(resend_ip), .resend_port(resend_port), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle counter doubles as the watchdog for a hung tracker.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Work out the results of one accepted request and update the table.
    task automatic predict_request(input logic [1:0] m, input logic [31:0] usr,
                                   input logic [31:0] ses, input logic [31:0] sq,
                                   input logic [1:0] ver, input logic [3:0] rty,
                                   input logic [7:0] tmo, input logic [31:0] ip,
                                   input logic [15:0] port, input logic [31:0] ast);
        tracker_result_t r;
        tracker_result_t tick_res[$];
        logic [31:0] stp;
        logic [7:0]  use_tmo;
        logic [31:0] use_ip;
        logic [15:0] use_port;
        int free_idx;
        int peer_idx;
        bit resent;
        stp = usr + sq;
        if (m == MODE_SEND)
        begin
            r = '0;
            r.stamp = stp;
            r.owner = usr;
            r.last  = 1'b1;
            r.kind  = KIND_UNTRACKED;
            if (ver <= VER_LAST_TRACKED)
            begin
                // A new session of this user retires its older packets.
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i] && tbl_user[i] == usr && tbl_session[i] != ses)
                        tbl_valid[i] = 1'b0;
                free_idx = -1;
                peer_idx = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        if (peer_idx < 0 && tbl_user[i] == usr)
                            peer_idx = i;
                    end
                    else if (free_idx < 0)
                        free_idx = i;
                end
                if (free_idx >= 0)
                begin
                    use_tmo = tmo;
                    use_ip = ip;
                    use_port = port;
                    if (peer_idx >= 0)
                    begin
                        use_tmo = tbl_reload[peer_idx];
                        use_ip = tbl_ip[peer_idx];
                        use_port = tbl_port[peer_idx];
                    end
                    tbl_valid[free_idx]   = 1'b1;
                    tbl_user[free_idx]    = usr;
                    tbl_session[free_idx] = ses;
                    tbl_stamp[free_idx]   = stp;
                    tbl_retries[free_idx] = rty;
                    tbl_count[free_idx]   = use_tmo;
                    tbl_reload[free_idx]  = use_tmo;
                    tbl_ip[free_idx]      = use_ip;
                    tbl_port[free_idx]    = use_port;
                    r.kind = KIND_TRACKED;
                    r.slot = free_idx[3:0];
                    r.ip   = use_ip;
                    r.port = use_port;
                end
            end
            pending_results.push_back(r);
        end
        else if (m == MODE_ACK)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (tbl_valid[i] && tbl_user[i] == usr && tbl_stamp[i] == ast)
                    tbl_valid[i] = 1'b0;
        end
        else if (m == MODE_TICK)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (tbl_valid[i])
                begin
                    resent = 0;
                    r = '0;
                    r.slot  = i[3:0];
                    r.stamp = tbl_stamp[i];
                    r.owner = tbl_user[i];
                    r.ip    = tbl_ip[i];
                    r.port  = tbl_port[i];
                    if (tbl_count[i] == 0 && tbl_retries[i] != 0)
                    begin
                        r.kind = KIND_RESEND;
                        tick_res.push_back(r);
                        tbl_retries[i] = tbl_retries[i] - 4'd1;
                        tbl_count[i] = tbl_reload[i];
                        resent = 1;
                    end
                    // A last resend with zero reload also frees the slot.
                    if (tbl_count[i] == 0 && tbl_retries[i] == 0)
                    begin
                        if (!resent)
                        begin
                            r.kind = KIND_EXPIRED;
                            tick_res.push_back(r);
                        end
                        tbl_valid[i] = 1'b0;
                    end
                    else if (tbl_count[i] != 0)
                        tbl_count[i] = tbl_count[i] - 8'd1;
                end
            end
            if (tick_res.size() > 0)
                tick_res[tick_res.size() - 1].last = 1'b1;
            foreach (tick_res[k])
                pending_results.push_back(tick_res[k]);
        end
    endtask

    // Present one request after a random gap and hold it until accepted.
    // Valid stays high after acceptance; the next gap or a drain lowers it.
    task automatic send_request(input logic [1:0] m, input logic [31:0] usr,
                                input logic [31:0] ses, input logic [31:0] sq,
                                input logic [1:0] ver, input logic [3:0] rty,
                                input logic [7:0] tmo, input logic [31:0] ip,
                                input logic [15:0] port, input logic [31:0] ast);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        user_id       <= usr;
        session_id    <= ses;
        seq_number    <= sq;
        proto_version <= ver;
        retry_count   <= rty;
        timeout_ticks <= tmo;
        dest_ip       <= ip;
        dest_port     <= port;
        ack_tag       <= ast;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Predict at acceptance so expectations line up with the result order.
        predict_request(m, usr, ses, sq, ver, rty, tmo, ip, port, ast);
        if (m == MODE_SEND && ver <= VER_LAST_TRACKED)
        begin
            recent_stamp.push_back(usr + sq);
            recent_user.push_back(usr);
            if (recent_stamp.size() > 24)
            begin
                void'(recent_stamp.pop_front());
                void'(recent_user.pop_front());
            end
        end
        requests_sent++;
    endtask

    // Random send built from the user and session pools.
    task automatic send_random_packet(input int tmo_max);
        send_request(MODE_SEND, user_pool[$urandom_range(0, 3)],
                     sess_pool[$urandom_range(0, 1)], $urandom,
                     ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1)),
                     4'($urandom), 8'($urandom_range(0, tmo_max)), $urandom,
                     16'($urandom), $urandom);
    endtask

    task automatic send_tick();
        send_request(MODE_TICK, $urandom, $urandom, $urandom, 2'($urandom),
                     4'($urandom), 8'($urandom), $urandom, 16'($urandom), $urandom);
    endtask

    // Stop sending and wait for every predicted result to arrive.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    // Result side: the stall is drawn afresh for each result.
    initial
    begin : result_stall_gen
        int hold;
        forever
        begin
            @(posedge clk);
            if (!stall_random)
                out_stall <= 1'b0;
            else if (!out_stall && out_valid)
            begin
                hold = $urandom_range(0, 8);
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        tracker_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result kind=%0d slot=%0d stamp=%h",
                         $time, kind, slot, stamp);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t kind exp %0d got %0d", $time, want.kind, kind);
                    errors++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t slot exp %0d got %0d", $time, want.slot, slot);
                    errors++;
                end
                if (stamp !== want.stamp)
                begin
                    $display("%0t stamp exp %h got %h", $time, want.stamp, stamp);
                    errors++;
                end
                if (owner_id !== want.owner)
                begin
                    $display("%0t owner exp %h got %h", $time, want.owner, owner_id);
                    errors++;
                end
                if (resend_ip !== want.ip)
                begin
                    $display("%0t ip exp %h got %h", $time, want.ip, resend_ip);
                    errors++;
                end
                if (resend_port !== want.port)
                begin
                    $display("%0t port exp %h got %h", $time, want.port, resend_port);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t last exp %0d got %0d", $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    // Field extremes, untracked versions, the no-op and a plain ack.
    task automatic test_directed_fields();
        send_request(MODE_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1,
                     4'hF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_SEND, 32'h0, 32'h0, 32'h0, 2'd0, 4'h0, 8'h0,
                     32'h0, 16'h0, 32'h0);
        send_request(MODE_SEND, 32'h1234, 32'h1, 32'h10, 2'd2, 4'h3, 8'h4,
                     32'hA, 16'hB, 32'h0);
        send_request(MODE_SEND, 32'h1234, 32'h1, 32'h10, 2'd3, 4'h3, 8'h4,
                     32'hA, 16'hB, 32'h0);
        send_request(MODE_NOP, 32'hFFFF_FFFF, 32'h0, 32'h0, 2'd0, 4'h0, 8'h0,
                     32'h0, 16'h0, 32'h0);
        // The zero-timeout, zero-retry entry expires on the first tick.
        send_tick();
        // Ack the all-ones entry: stamp is all-ones plus all-ones.
        send_request(MODE_ACK, 32'hFFFF_FFFF, 32'h0, 32'h0, 2'd0, 4'h0, 8'h0,
                     32'h0, 16'h0, 32'hFFFF_FFFE);
        send_tick();
        wait_results_drained();
    endtask

    // Resend chains, the combined last resend and expire, and session purge.
    task automatic test_directed_timers();
        send_request(MODE_SEND, 32'h55, 32'h1, 32'h1, 2'd0, 4'h1, 8'h0,
                     32'h11, 16'h22, 32'h0);
        send_request(MODE_SEND, 32'h66, 32'h1, 32'h1, 2'd1, 4'h2, 8'h1,
                     32'h33, 16'h44, 32'h0);
        // Same user and session: inherits the earlier destination and timeout.
        send_request(MODE_SEND, 32'h66, 32'h1, 32'h2, 2'd0, 4'h1, 8'h9,
                     32'h99, 16'h99, 32'h0);
        repeat (6) send_tick();
        send_request(MODE_SEND, 32'h77, 32'h1, 32'h5, 2'd0, 4'h4, 8'h3,
                     32'h1, 16'h1, 32'h0);
        // A new session of the same user purges the old entry.
        send_request(MODE_SEND, 32'h77, 32'h2, 32'h6, 2'd0, 4'h4, 8'h2,
                     32'h2, 16'h2, 32'h0);
        repeat (6) send_tick();
        wait_results_drained();
    endtask

    // Fill the table past its depth so that sends come back untracked.
    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(MODE_SEND, 32'h100 + i, 32'h7, i, 2'd0, 4'h0, 8'hFF,
                         i, i[15:0], 32'h0);
        for (int i = 0; i < DEPTH; i++)
            send_request(MODE_ACK, 32'h100 + i, 32'h0, 32'h0, 2'd0, 4'h0, 8'h0,
                         32'h0, 16'h0, 32'h100 + 2 * i);
        send_tick();
        wait_results_drained();
    endtask

    // Mostly well-formed traffic: sends, acks of live stamps and ticks.
    task automatic test_random_traffic(input int count, input int tmo_max);
        int pick;
        int idx;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_random_packet(tmo_max);
            else if (pick < 55 && recent_stamp.size() > 0)
            begin
                idx = $urandom_range(0, recent_stamp.size() - 1);
                send_request(MODE_ACK, recent_user[idx], $urandom, $urandom,
                             2'($urandom), 4'($urandom), 8'($urandom), $urandom,
                             16'($urandom), recent_stamp[idx]);
            end
            else if (pick < 60)
                send_request(MODE_ACK, $urandom, $urandom, $urandom, 2'($urandom),
                             4'($urandom), 8'($urandom), $urandom, 16'($urandom),
                             $urandom);
            else if (pick < 63)
                send_request(MODE_NOP, $urandom, $urandom, $urandom, 2'($urandom),
                             4'($urandom), 8'($urandom), $urandom, 16'($urandom),
                             $urandom);
            else
                send_tick();
            // Halfway through, the sender holds off until the tracker is empty.
            if (n == count / 2)
                wait_results_drained();
        end
    endtask

    initial
    begin : main_sequence
        errors = 0;
        cycles = 0;
        requests_sent = 0;
        results_seen = 0;
        stall_random = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        mode = MODE_NOP;
        user_id = '0;
        session_id = '0;
        seq_number = '0;
        proto_version = '0;
        retry_count = '0;
        timeout_ticks = '0;
        dest_ip = '0;
        dest_port = '0;
        ack_tag = '0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;
        foreach (user_pool[i])
            user_pool[i] = $urandom;
        foreach (sess_pool[i])
            sess_pool[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_fields();
        test_directed_timers();
        test_full_table();
        // Short timeouts make resends and expiries frequent.
        test_random_traffic(120, 3);
        // A stretch with no result stalls and wider timeouts.
        stall_random = 1'b0;
        test_random_traffic(50, 255);
        stall_random = 1'b1;
        test_random_traffic(80, 6);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d requests and %0d results: sends, acks, ticks, no-ops,",
                 requests_sent, results_seen);
        $display("untracked versions, a full table, session purges and resends.");
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[ack_retransmit_tracker_top.f]
+incdir+design
design/art_pkg.sv
design/art_front.sv
design/art_back.sv
design/ack_retransmit_tracker_top.sv
verif/ack_retransmit_tracker_top_tb.sv
